/* rtl/hng_pkg.sv */
// ----------------------------------------------------------------------------
// hng_pkg
// Shared types, widths and register indexes of the height map normal
// generator.
// ----------------------------------------------------------------------------
package hng_pkg;

   localparam int MAX_WIDTH        = 1024;
   localparam int NORMAL_FRAC_BITS = 14;

   localparam int ADDR_W   = $clog2(MAX_WIDTH);
   localparam int SAMPLE_W = 8;
   localparam int CFG_W    = 11;
   localparam int DIV_CFG_W = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int OUT_W    = 16;

   // Vector components: 2*(a-b) needs 10 bits, -4*s needs 11 bits.
   localparam int V_W      = 11;
   localparam int VSQ_W    = 2 * V_W - 1;
   localparam int SQ_W     = VSQ_W;
   localparam int REM_W    = SQ_W + 1;

   // Quotient of v^2 * 2^(2F+2) / |v|^2 and its integer square root.
   localparam int Q_W        = 2 * NORMAL_FRAC_BITS + 3;
   localparam int DIV_STEPS  = Q_W;
   localparam int ROOT_W     = NORMAL_FRAC_BITS + 2;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int RREM_W     = ROOT_W + 3;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam int COMP_W = 2;
   localparam logic [COMP_W-1:0] COMP_X = 2'd0;
   localparam logic [COMP_W-1:0] COMP_Y = 2'd1;
   localparam logic [COMP_W-1:0] COMP_Z = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEIGHT_DIVISOR = 2'd2;

   localparam logic [CFG_W-1:0]     WIDTH_RESET   = 11'd512;
   localparam logic [CFG_W-1:0]     HEIGHT_RESET  = 11'd512;
   localparam logic [DIV_CFG_W-1:0] DIVISOR_RESET = 8'd25;
   localparam logic [CFG_W-1:0]     MAX_WIDTH_C   = CFG_W'(MAX_WIDTH);

   typedef struct packed {
      logic              clear_wr;
      logic [ADDR_W-1:0] clear_addr;
      logic              accept;
      logic              fetch;
      logic              form;
      logic              sq;
      logic              div_init;
      logic              div_step;
      logic              root_init;
      logic              root_step;
      logic              store;
      logic              out_load;
      logic [COMP_W-1:0] comp;
   } hng_cmd_type;

   typedef struct packed {
      logic emit;
      logic out_busy;
   } hng_stat_type;

endpackage

/* rtl/heightmap_normal_generator_top.sv */
// ----------------------------------------------------------------------------
// heightmap_normal_generator_top
// Unit surface normals of a streamed height map by central differences.
// ----------------------------------------------------------------------------
// Samples arrive in raster order, followed by one padding row. From the second
// row on each accepted beat yields the Q1.14 normal of the pixel one row above
// it. After reset a clearing pass zeroes the line store before the first beat
// is taken. A beat that yields no normal returns to idle after the fetch and
// form steps; one that yields a normal also passes through the single shared
// divider and square root unit, which works on the three components in turn
// with 31 division steps and 16 root steps each. The next beat is accepted
// while a finished normal still waits in the output register.
module heightmap_normal_generator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [hng_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [hng_pkg::CFG_W-1:0]         csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hng_pkg::SAMPLE_W-1:0]      req_tdata,   // [7:0] height_sample
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [3*hng_pkg::OUT_W-1:0]       rsp_tdata,   // [47:32] normal_z, [31:16] normal_y, [15:0] normal_x
   output logic                              rsp_tlast
);
   import hng_pkg::*;

   hng_cmd_type  cmd;
   hng_stat_type stat;

   hng_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   hng_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_sample (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/hng_ctrl.sv */
// ----------------------------------------------------------------------------
// hng_ctrl
// Sequencer: line store clearing, fetch, and the iterations of the shared
// divider and square root unit.
// ----------------------------------------------------------------------------
module hng_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  hng_pkg::hng_stat_type stat,
   output hng_pkg::hng_cmd_type  cmd
);
   import hng_pkg::*;

   typedef enum logic [10:0] {
      ST_CLEAR = 11'b000_0000_0001,
      ST_IDLE  = 11'b000_0000_0010,
      ST_FETCH = 11'b000_0000_0100,
      ST_FORM  = 11'b000_0000_1000,
      ST_SQ    = 11'b000_0001_0000,
      ST_DIVI  = 11'b000_0010_0000,
      ST_DIV   = 11'b000_0100_0000,
      ST_ROOTI = 11'b000_1000_0000,
      ST_ROOT  = 11'b001_0000_0000,
      ST_STORE = 11'b010_0000_0000,
      ST_OUTW  = 11'b100_0000_0000
   } hng_state_type;

   hng_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [COMP_W-1:0] comp_ff, comp_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
         comp_ff  <= COMP_X;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         comp_ff  <= comp_in;
         clr_ff   <= clr_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      comp_in  = comp_ff;
      clr_in   = clr_ff;
      cmd      = '0;
      cmd.comp = comp_ff;
      cmd.clear_addr = clr_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(MAX_WIDTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in = ST_FORM;
         end
         ST_FORM: begin
            cmd.form = 1'b1;
            comp_in = COMP_X;
            state_in = stat.emit ? ST_SQ : ST_IDLE;
         end
         ST_SQ: begin
            cmd.sq = 1'b1;
            if (comp_ff == COMP_Z) begin
               comp_in = COMP_X;
               state_in = ST_DIVI;
            end else begin
               comp_in = comp_ff + 1'b1;
            end
         end
         ST_DIVI: begin
            cmd.div_init = 1'b1;
            step_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_ROOTI;
            end
         end
         ST_ROOTI: begin
            cmd.root_init = 1'b1;
            step_in = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (comp_ff == COMP_Z) begin
               comp_in = COMP_X;
               state_in = ST_OUTW;
            end else begin
               comp_in = comp_ff + 1'b1;
               state_in = ST_DIVI;
            end
         end
         ST_OUTW: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_accept_fetch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_tvalid) |=> state_ff == ST_FETCH)
      else $error("accepted beat did not start a fetch");

   a_out_release: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUTW && !stat.out_busy) |=> state_ff == ST_IDLE)
      else $error("result held although output register was free");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!cmd.accept && !cmd.fetch))
      else $error("line store accessed during clearing pass");

endmodule

/* rtl/hng_datapath.sv */
// ----------------------------------------------------------------------------
// hng_datapath
// Configuration registers, line store, position counters, central
// difference vector and the shared bit-serial divider and square root.
// ----------------------------------------------------------------------------
module hng_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [hng_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [hng_pkg::CFG_W-1:0]         csr_wdata,
   input  logic [hng_pkg::SAMPLE_W-1:0]      req_sample,
   input  hng_pkg::hng_cmd_type              cmd,
   output hng_pkg::hng_stat_type             stat,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [3*hng_pkg::OUT_W-1:0]       rsp_tdata,
   output logic                              rsp_tlast
);
   import hng_pkg::*;

   logic [CFG_W-1:0]     width_ff, height_ff;
   logic [DIV_CFG_W-1:0] divisor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         divisor_ff <= DIVISOR_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_IMAGE_WIDTH:    width_ff   <= csr_wdata;
            CSR_IMAGE_HEIGHT:   height_ff  <= csr_wdata;
            CSR_HEIGHT_DIVISOR: divisor_ff <= csr_wdata[DIV_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   logic [CFG_W-1:0]     w_eff, h_eff, col_inc;
   logic [DIV_CFG_W-1:0] s_eff;
   logic [ADDR_W-1:0]    col_ff;
   logic [CFG_W-1:0]     row_ff;
   logic                 pad, row_end;

   assign w_eff = (width_ff == '0) ? CFG_W'(1) :
                  (width_ff > MAX_WIDTH_C) ? MAX_WIDTH_C : width_ff;
   assign h_eff = (height_ff == '0) ? CFG_W'(1) : height_ff;
   assign s_eff = (divisor_ff == '0) ? DIV_CFG_W'(1) : divisor_ff;
   assign col_inc = CFG_W'(col_ff) + 1'b1;
   assign pad     = row_ff >= h_eff;
   assign row_end = col_inc >= w_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.accept) begin
         if (row_end) begin
            col_ff <= '0;
            row_ff <= pad ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // Item captured at acceptance.
   logic [ADDR_W-1:0]    icol_ff;
   logic [SAMPLE_W-1:0]  b_ff, lv_ff, above_ff, left_ff;
   logic                 right_ok_ff, top_ok_ff, emit_ff, last_ff;
   logic [DIV_CFG_W-1:0] s_ff;

   // Line store: upper byte is the older row, lower byte the previous row.
   logic [2*SAMPLE_W-1:0] line_mem [MAX_WIDTH];
   logic [2*SAMPLE_W-1:0] mem_q_ff;
   logic [ADDR_W-1:0]     rd_addr;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         icol_ff     <= col_ff;
         b_ff        <= pad ? '0 : req_sample;
         lv_ff       <= (col_ff != '0) ? left_ff : '0;
         right_ok_ff <= col_inc < w_eff;
         top_ok_ff   <= row_ff >= CFG_W'(2);
         last_ff     <= pad && row_end;
         s_ff        <= s_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         if (cmd.accept) begin
            emit_ff <= row_ff != '0;
         end
         if (cmd.fetch) begin
            left_ff <= mem_q_ff[SAMPLE_W-1:0];
         end
      end
   end

   assign rd_addr = cmd.accept ? col_ff : icol_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         line_mem[cmd.clear_addr] <= '0;
      end else if (cmd.fetch) begin
         line_mem[icol_ff] <= {mem_q_ff[SAMPLE_W-1:0], b_ff};
      end
      mem_q_ff <= line_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         above_ff <= top_ok_ff ? mem_q_ff[2*SAMPLE_W-1:SAMPLE_W] : '0;
      end
   end

   // Central difference vector.
   logic signed [V_W-1:0] vx_ff, vy_ff, vz_ff, v_sel;
   logic [SAMPLE_W-1:0]   rv;
   logic signed [V_W-1:0] dxh, dzh;

   assign rv  = right_ok_ff ? mem_q_ff[SAMPLE_W-1:0] : '0;
   assign dxh = $signed(V_W'(rv)) - $signed(V_W'(lv_ff));
   assign dzh = $signed(V_W'(b_ff)) - $signed(V_W'(above_ff));

   always_ff @(posedge clock) begin
      if (cmd.form) begin
         vx_ff <= dxh <<< 1;
         vy_ff <= -$signed({1'b0, s_ff, 2'b00});
         vz_ff <= dzh <<< 1;
      end
   end

   always_comb begin
      case (cmd.comp)
         COMP_X:  v_sel = vx_ff;
         COMP_Y:  v_sel = vy_ff;
         COMP_Z:  v_sel = vz_ff;
         default: v_sel = vx_ff;
      endcase
   end

   logic signed [2*V_W-1:0] prod;
   logic [VSQ_W-1:0]        vsq;
   logic [SQ_W-1:0]         sq_ff;

   assign prod = v_sel * v_sel;
   assign vsq  = VSQ_W'(prod);

   always_ff @(posedge clock) begin
      if (cmd.sq) begin
         sq_ff <= ((cmd.comp == COMP_X) ? '0 : sq_ff) + SQ_W'(vsq);
      end
   end

   // Restoring division: quotient of v^2 * 2^(Q_W-1) by the squared length.
   logic [REM_W-1:0] rem_ff, rem_diff;
   logic [Q_W-1:0]   quo_ff;
   logic             rem_ge;

   assign rem_ge   = rem_ff >= REM_W'(sq_ff);
   assign rem_diff = rem_ge ? rem_ff - REM_W'(sq_ff) : rem_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= REM_W'(vsq);
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= {rem_diff[REM_W-2:0], 1'b0};
         quo_ff <= {quo_ff[Q_W-2:0], rem_ge};
      end
   end

   // Digit-by-digit integer square root, two radicand bits per step.
   logic [RAD_W-1:0]  rad_ff;
   logic [RREM_W-1:0] rrem_ff, rcur, rtrial;
   logic [ROOT_W-1:0] root_ff;
   logic              rfit;

   assign rcur   = {rrem_ff[RREM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
   assign rtrial = RREM_W'({root_ff, 2'b01});
   assign rfit   = rcur >= rtrial;

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         rad_ff  <= RAD_W'(quo_ff);
         rrem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rrem_ff <= rfit ? rcur - rtrial : rcur;
         root_ff <= {root_ff[ROOT_W-2:0], rfit};
      end
   end

   // Largest odd number not above the root gives the rounded component.
   logic [ROOT_W:0]   root_p1;
   logic [OUT_W-1:0]  mag, comp_val;
   logic [OUT_W-1:0]  nx_ff, ny_ff, nz_ff;

   assign root_p1  = {1'b0, root_ff} + 1'b1;
   assign mag      = OUT_W'(root_p1[ROOT_W:1]);
   assign comp_val = v_sel[V_W-1] ? -mag : mag;

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         case (cmd.comp)
            COMP_X:  nx_ff <= comp_val;
            COMP_Y:  ny_ff <= comp_val;
            COMP_Z:  nz_ff <= comp_val;
            default: nx_ff <= comp_val;
         endcase
      end
   end

   // Output register.
   logic             out_valid_ff;
   logic [OUT_W-1:0] ox_ff, oy_ff, oz_ff;
   logic             olast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         ox_ff    <= nx_ff;
         oy_ff    <= ny_ff;
         oz_ff    <= nz_ff;
         olast_ff <= last_ff;
      end
   end

   assign rsp_tvalid    = out_valid_ff;
   assign rsp_tdata     = {oz_ff, oy_ff, ox_ff};
   assign rsp_tlast     = olast_ff;
   assign stat.emit     = emit_ff;
   assign stat.out_busy = out_valid_ff && !rsp_tready;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(out_valid_ff && !rsp_tready))
      else $error("pending result overwritten");

   a_y_nonpositive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (oy_ff[OUT_W-1] || oy_ff == '0))
      else $error("vertical normal component positive");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < (REM_W'(sq_ff) << 1))
      else $error("division remainder out of range");

endmodule

/* verif/tb_heightmap_normal_generator_top.sv */
// ----------------------------------------------------------------------------
// Height map normal generator testbench
// Streams height maps of assorted sizes into the block, in raster order with
// their padding rows, and predicts each unit normal from a line-store model
// kept in the bench or takes it from the directed table. Both channels idle
// in random bursts. Once, the receiver holds off long enough to back the
// block up. All three registers are swept, out-of-range values included.
// ----------------------------------------------------------------------------
module tb_heightmap_normal_generator_top;
   import hng_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 8000;
   localparam int SETTLE_CYCLES  = 400;
   localparam int HOLD_CYCLES    = 2000;

   typedef struct packed {
      logic signed [OUT_W-1:0] nx;
      logic signed [OUT_W-1:0] ny;
      logic signed [OUT_W-1:0] nz;
      logic                    last;
   } normal_type;

   typedef struct {
      int unsigned wid;
      int unsigned hgt;
      int unsigned dvs;
      logic [7:0]  smp;
      bit          typed;
      normal_type  nrm;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr = '0;
   logic [CFG_W-1:0]        csr_wdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [SAMPLE_W-1:0]     req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [3*OUT_W-1:0]      rsp_tdata;
   logic                    rsp_tlast;

   heightmap_normal_generator_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Bench copy of the block state.
   logic [7:0]  older_row [MAX_WIDTH];
   logic [7:0]  prev_row [MAX_WIDTH];
   int unsigned col_cnt, row_cnt;
   logic [7:0]  left_smp;
   int unsigned cfg_width = 512, cfg_height = 512, cfg_div = 25;

   normal_type  pending_normals[$];
   int          error_count;
   bit          calm;
   int          hold_requests, hold_served;
   int unsigned items_sent;

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // Rounded |v| * 2^F / sqrt(sq), found by bisection on exact integers.
   function automatic logic signed [OUT_W-1:0] unit_comp(input longint v,
                                                          input longint unsigned sq);
      longint unsigned mag, rhs, lo, hi, mid, odd;
      mag = v < 0 ? -v : v;
      rhs = 4 * mag * mag * (64'd1 << (2 * NORMAL_FRAC_BITS));
      lo = 0;
      hi = 64'd1 << NORMAL_FRAC_BITS;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         odd = 2 * mid - 1;
         if (odd * odd * sq <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return v < 0 ? -OUT_W'(lo) : OUT_W'(lo);
   endfunction

   function automatic bit predict_normal(input logic [7:0] smp, output normal_type nrm);
      int unsigned w, h, s, c, r;
      bit          pad, row_end, got;
      logic [7:0]  b, above, old_prev;
      longint      lv, rv, tv, dx, dy, dz;
      longint unsigned sq;
      w = cfg_width == 0 ? 1 : (cfg_width > MAX_WIDTH ? MAX_WIDTH : cfg_width);
      h = cfg_height == 0 ? 1 : cfg_height;
      s = cfg_div == 0 ? 1 : cfg_div;
      c = col_cnt >= MAX_WIDTH ? MAX_WIDTH - 1 : col_cnt;
      r = row_cnt;
      pad = r >= h;
      row_end = c + 1 >= w;
      b = pad ? 8'd0 : smp;
      above = older_row[c];
      old_prev = prev_row[c];
      got = r >= 1;
      nrm = '0;
      if (got) begin
         lv = c > 0 ? left_smp : 0;
         rv = c + 1 < w ? prev_row[c+1] : 0;
         tv = r >= 2 ? above : 0;
         dx = 2 * (rv - lv);
         dy = -4 * longint'(s);
         dz = 2 * (longint'(b) - tv);
         sq = dx * dx + dy * dy + dz * dz;
         nrm.nx = unit_comp(dx, sq);
         nrm.ny = unit_comp(dy, sq);
         nrm.nz = unit_comp(dz, sq);
         nrm.last = pad && row_end;
      end
      older_row[c] = old_prev;
      prev_row[c] = b;
      left_smp = old_prev;
      if (row_end) begin
         col_cnt = 0;
         row_cnt = pad ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
      end
      return got;
   endfunction

   // Registers change only once the block has drained and settled.
   task automatic set_config(input int unsigned w, input int unsigned h, input int unsigned s);
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= CSR_IMAGE_WIDTH;
      csr_wdata <= CFG_W'(w);
      @(posedge clock);
      csr_addr <= CSR_IMAGE_HEIGHT;
      csr_wdata <= CFG_W'(h);
      @(posedge clock);
      csr_addr <= CSR_HEIGHT_DIVISOR;
      csr_wdata <= CFG_W'(s);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_width = w & 11'h7FF;
      cfg_height = h & 11'h7FF;
      cfg_div = s & 8'hFF;
   endtask

   task automatic send_sample(input logic [7:0] smp, input bit typed,
                              input normal_type typed_nrm);
      normal_type nrm;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= smp;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (predict_normal(smp, nrm)) pending_normals.push_back(typed ? typed_nrm : nrm);
   endtask

   function automatic logic [7:0] rand_height();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned s,
                            input int unsigned count);
      set_config(w, h, s);
      repeat (count) send_sample(rand_height(), 1'b0, '0);
      req_tvalid <= 1'b0;
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   int stall_left, hold_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker and watchdog.
   int idle_cycles;
   always @(posedge clock) begin
      normal_type want, seen;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = {rsp_tdata[OUT_W-1:0], rsp_tdata[2*OUT_W-1:OUT_W],
                 rsp_tdata[3*OUT_W-1:2*OUT_W], rsp_tlast};
         if (pending_normals.size() == 0) begin
            report_mismatch($sformatf("unexpected normal %p", seen));
         end else begin
            want = pending_normals.pop_front();
            if (seen.nx !== want.nx)
               report_mismatch($sformatf("normal_x %0d, want %0d", seen.nx, want.nx));
            if (seen.ny !== want.ny)
               report_mismatch($sformatf("normal_y %0d, want %0d", seen.ny, want.ny));
            if (seen.nz !== want.nz)
               report_mismatch($sformatf("normal_z %0d, want %0d", seen.nz, want.nz));
            if (seen.last !== want.last)
               report_mismatch($sformatf("last %0b, want %0b", seen.last, want.last));
         end
      end
   end

   // A flat image gives straight-down normals; the final one carries last.
   localparam normal_type FLAT      = '{nx: 16'sd0, ny: -16'sd16384, nz: 16'sd0, last: 1'b0};
   localparam normal_type FLAT_LAST = '{nx: 16'sd0, ny: -16'sd16384, nz: 16'sd0, last: 1'b1};

   // The first beat here closes the row left open by the reset stretch.
   stim_row_type directed[] = '{
      '{2, 2, 1, 8'd0,   0, '0}, '{2, 2, 1, 8'd0,   1, FLAT},
      '{2, 2, 1, 8'd0,   1, FLAT}, '{2, 2, 1, 8'd0, 1, FLAT},
      '{2, 2, 1, 8'd0,   1, FLAT_LAST}, '{2, 2, 1, 8'd0, 0, '0},
      // Padding samples are nonzero here but must read as zero.
      '{2, 2, 255, 8'd255, 0, '0}, '{2, 2, 255, 8'd0,   0, '0},
      '{2, 2, 255, 8'd0,   0, '0}, '{2, 2, 255, 8'd255, 0, '0},
      '{2, 2, 255, 8'd255, 0, '0}, '{2, 2, 255, 8'd255, 0, '0},
      '{3, 2, 1, 8'd255, 0, '0}, '{3, 2, 1, 8'd0,   0, '0}, '{3, 2, 1, 8'd255, 0, '0},
      '{3, 2, 1, 8'd0,   0, '0}, '{3, 2, 1, 8'd255, 0, '0}, '{3, 2, 1, 8'd0,   0, '0},
      '{3, 2, 1, 8'd170, 0, '0}, '{3, 2, 1, 8'd85,  0, '0}, '{3, 2, 1, 8'd1,   0, '0}
   };

   initial begin
      int unsigned w, h, n;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         older_row[i] = '0;
         prev_row[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset values first: a short stretch of a 512 wide image.
      repeat (20) send_sample(8'd0, 1'b0, '0);
      req_tvalid <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].wid != cfg_width || directed[i].hgt != cfg_height ||
             directed[i].dvs != cfg_div) begin
            req_tvalid <= 1'b0;
            set_config(directed[i].wid, directed[i].hgt, directed[i].dvs);
         end
         send_sample(directed[i].smp, directed[i].typed, directed[i].nrm);
      end
      req_tvalid <= 1'b0;

      // Widest rows.
      set_config(1024, 2, 255);
      repeat (240) send_sample(rand_height(), 1'b0, '0);
      req_tvalid <= 1'b0;

      // Narrow rows with the receiver holding off, so the block backs up.
      set_config(8, 4, 200);
      hold_requests++;
      repeat (40) send_sample(rand_height(), 1'b0, '0);
      req_tvalid <= 1'b0;

      run_phase(0, 2, 7, 12);          // zero width acts as one
      run_phase(2047, 2047, 0, 80);    // clamps; zero divisor acts as one
      run_phase(4, 0, 128, 24);        // zero height acts as one
      run_phase(2, 1024, 64, 30);

      while (items_sent < 1350) begin
         w = $urandom_range(0, 7) == 0 ? $urandom_range(13, 40) : $urandom_range(2, 12);
         h = $urandom_range(2, 8);
         if (items_sent > 1150) calm = 1'b1;
         n = w * (h + 1) * $urandom_range(1, 2);
         if (n > 1350 - items_sent) n = 1350 - items_sent;
         run_phase(w, h, $urandom_range(0, 255), n);
      end

      while (pending_normals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
